// ----- hw/rtl/toroidal_grid_diffusion_step_core_defines.svh -----
// Assertion helpers shared by the RTL files.
`ifndef TOROIDAL_GRID_DIFFUSION_STEP_CORE_DEFINES_SVH
`define TOROIDAL_GRID_DIFFUSION_STEP_CORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising edge outside reset.
`define TGDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TGDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TGDS_ASSERT_IMP(lbl, ante, cons, msg)
`define TGDS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/tgds_pkg.sv -----
package tgds_pkg;

  localparam int COORD_W = 5;
  localparam int DIM_W   = 6;
  localparam int ADDR_W  = 2 * COORD_W;
  localparam int CONC_W  = 16;
  localparam int CELL_W  = 3 * CONC_W;
  localparam int SUM_W   = 20;
  localparam int COEF_W  = 14;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0]  DIM_MAX = 6'd32;
  localparam logic [COEF_W-1:0] D_CAP   = 14'd8192;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_COEFF  = 2'd2,
    CFG_INIT_A = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_CLEAR,
    ST_SW_START,
    ST_SW_RD,
    ST_SW_LAST,
    ST_MUL,
    ST_FIN,
    ST_SW_WR,
    ST_CP_RD,
    ST_CP_WR,
    ST_DONE
  } state_t;

  // Control from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic mul_en;
  } alu_ctrl_t;

endpackage

// ----- hw/rtl/toroidal_grid_diffusion_step_core.sv -----
// Channel   Direction  Handshake         Payload
// in_*      input      in_valid/in_stall operation, col, row, three Q8.8 values
// out_*     output     out_valid/out_stall status, three Q8.8 values
// cfg_*     input      cfg_we            cfg_index, cfg_wdata
//
// A diffusion step sweeps all 1024 cells: each cell in the region takes a start
// state, nine memory reads, one drain state, three multiply/add passes of the shared
// unit and the write; each cell outside is read and copied.
// Reset (rst_n low, synchronous) clears control and selects bank zero; cell memory
// is not cleared. The block takes a new request while a result waits on out_stall.
`include "toroidal_grid_diffusion_step_core_defines.svh"

module toroidal_grid_diffusion_step_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_operation,
  input  logic [tgds_pkg::COORD_W-1:0]      in_col,
  input  logic [tgds_pkg::COORD_W-1:0]      in_row,
  input  logic [tgds_pkg::CONC_W-1:0]       in_conc_a_in,
  input  logic [tgds_pkg::CONC_W-1:0]       in_conc_b_in,
  input  logic [tgds_pkg::CONC_W-1:0]       in_conc_c_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_status,
  output logic [tgds_pkg::CONC_W-1:0]       out_conc_a_out,
  output logic [tgds_pkg::CONC_W-1:0]       out_conc_b_out,
  output logic [tgds_pkg::CONC_W-1:0]       out_conc_c_out,
  input  logic                              cfg_we,
  input  logic [tgds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tgds_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int CW = tgds_pkg::CONC_W;
  localparam int AW = tgds_pkg::ADDR_W;
  localparam int PW = tgds_pkg::COORD_W;

  tgds_pkg::state_t state_r, state_nxt;

  // Configuration registers.
  logic [tgds_pkg::DIM_W-1:0]  gw_r, gh_r;
  logic [tgds_pkg::COEF_W-1:0] coeff_r;
  logic [CW-1:0]               init_a_r;

  // Latched request.
  tgds_pkg::op_t               op_r;
  logic [PW-1:0]               rcol_r, rrow_r;
  logic [tgds_pkg::CELL_W-1:0] wcell_r;

  // Sweep counters and accumulators.
  logic                        bank_r;
  logic [PW-1:0]               row_r, col_r;
  logic [1:0]                  kr_r, kc_r, ch_r;
  logic                        acc_en_r, acc_ctr_r;
  logic [tgds_pkg::SUM_W-1:0]  acc_r [3];
  logic [CW-1:0]               old_r [3];
  logic [CW-1:0]               new_r [3];

  // Pending and presented result.
  logic                        res_status_r;
  logic [tgds_pkg::CELL_W-1:0] res_cell_r;
  logic                        out_valid_r, out_status_r;
  logic [tgds_pkg::CELL_W-1:0] out_cell_r;

  // Two cell banks.
  logic [tgds_pkg::CELL_W-1:0] mem0 [1 << AW];
  logic [tgds_pkg::CELL_W-1:0] mem1 [1 << AW];
  logic [tgds_pkg::CELL_W-1:0] rd0_r, rd1_r, rdata;

  // Control strobes from the sequencer.
  logic                        mem_we, mem_wbank;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [tgds_pkg::CELL_W-1:0] mem_wdata;
  logic                        acc_clr, acc_issue, sw_adv, out_load, in_acc;
  tgds_pkg::alu_ctrl_t         alu_ctrl;

  // Effective geometry and capped coefficient.
  logic [tgds_pkg::DIM_W-1:0]  w_eff, h_eff, w_m1, h_m1;
  logic [PW-1:0]               w_last, h_last, nr, nc;
  logic [tgds_pkg::COEF_W-1:0] d_eff;
  logic                        in_region, req_oob, last_cell;
  logic [CW-1:0]               alu_res;

  always_comb begin
    if (gw_r == '0) begin
      w_eff = 6'd1;
    end else if (gw_r > tgds_pkg::DIM_MAX) begin
      w_eff = tgds_pkg::DIM_MAX;
    end else begin
      w_eff = gw_r;
    end
    if (gh_r == '0) begin
      h_eff = 6'd1;
    end else if (gh_r > tgds_pkg::DIM_MAX) begin
      h_eff = tgds_pkg::DIM_MAX;
    end else begin
      h_eff = gh_r;
    end
  end

  assign w_m1   = w_eff - 6'd1;
  assign h_m1   = h_eff - 6'd1;
  assign w_last = w_m1[PW-1:0];
  assign h_last = h_m1[PW-1:0];
  assign d_eff  = (coeff_r > tgds_pkg::D_CAP) ? tgds_pkg::D_CAP : coeff_r;

  assign in_region = ({1'b0, col_r} < w_eff) && ({1'b0, row_r} < h_eff);
  assign req_oob   = ({1'b0, rcol_r} >= w_eff) || ({1'b0, rrow_r} >= h_eff);
  assign last_cell = (row_r == '1) && (col_r == '1);
  assign in_acc    = in_valid && !in_stall;

  // Wrapped neighbor coordinates for the current stencil tap.
  always_comb begin
    case (kr_r)
      2'd0:    nr = (row_r == '0) ? h_last : row_r - 5'd1;
      2'd2:    nr = (row_r == h_last) ? '0 : row_r + 5'd1;
      default: nr = row_r;
    endcase
    case (kc_r)
      2'd0:    nc = (col_r == '0) ? w_last : col_r - 5'd1;
      2'd2:    nc = (col_r == w_last) ? '0 : col_r + 5'd1;
      default: nc = col_r;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tgds_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = tgds_pkg::ST_EXEC;
        end
      end
      tgds_pkg::ST_EXEC: begin
        unique case (op_r)
          tgds_pkg::OP_STEP:  state_nxt = tgds_pkg::ST_SW_START;
          tgds_pkg::OP_CLEAR: state_nxt = tgds_pkg::ST_CLEAR;
          tgds_pkg::OP_READ:  state_nxt = req_oob ? tgds_pkg::ST_DONE : tgds_pkg::ST_RDWAIT;
          default:            state_nxt = tgds_pkg::ST_DONE;
        endcase
      end
      tgds_pkg::ST_RDWAIT:   state_nxt = tgds_pkg::ST_DONE;
      tgds_pkg::ST_CLEAR: begin
        if (last_cell) begin
          state_nxt = tgds_pkg::ST_DONE;
        end
      end
      tgds_pkg::ST_SW_START: begin
        state_nxt = in_region ? tgds_pkg::ST_SW_RD : tgds_pkg::ST_CP_RD;
      end
      tgds_pkg::ST_SW_RD: begin
        if (kr_r == 2'd2 && kc_r == 2'd2) begin
          state_nxt = tgds_pkg::ST_SW_LAST;
        end
      end
      tgds_pkg::ST_SW_LAST:  state_nxt = tgds_pkg::ST_MUL;
      tgds_pkg::ST_MUL:      state_nxt = tgds_pkg::ST_FIN;
      tgds_pkg::ST_FIN: begin
        state_nxt = (ch_r == 2'd2) ? tgds_pkg::ST_SW_WR : tgds_pkg::ST_MUL;
      end
      tgds_pkg::ST_CP_RD:    state_nxt = tgds_pkg::ST_CP_WR;
      tgds_pkg::ST_SW_WR,
      tgds_pkg::ST_CP_WR: begin
        state_nxt = last_cell ? tgds_pkg::ST_DONE : tgds_pkg::ST_SW_START;
      end
      tgds_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = tgds_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tgds_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    mem_we    = 1'b0;
    mem_wbank = bank_r;
    mem_waddr = {row_r, col_r};
    mem_wdata = rdata;
    mem_raddr = {row_r, col_r};
    acc_clr   = 1'b0;
    acc_issue = 1'b0;
    sw_adv    = 1'b0;
    out_load  = 1'b0;
    alu_ctrl.mul_en = 1'b0;
    unique case (state_r)
      tgds_pkg::ST_EXEC: begin
        mem_raddr = {rrow_r, rcol_r};
        mem_waddr = {rrow_r, rcol_r};
        mem_wdata = wcell_r;
        mem_we    = (op_r == tgds_pkg::OP_WRITE) && !req_oob;
      end
      tgds_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = {{(2 * CW){1'b0}}, init_a_r};
        sw_adv    = 1'b1;
      end
      tgds_pkg::ST_SW_START: acc_clr = 1'b1;
      tgds_pkg::ST_SW_RD: begin
        mem_raddr = {nr, nc};
        acc_issue = 1'b1;
      end
      tgds_pkg::ST_MUL: alu_ctrl.mul_en = 1'b1;
      tgds_pkg::ST_SW_WR: begin
        mem_we    = 1'b1;
        mem_wbank = !bank_r;
        mem_wdata = {new_r[2], new_r[1], new_r[0]};
        sw_adv    = 1'b1;
      end
      tgds_pkg::ST_CP_WR: begin
        mem_we    = 1'b1;
        mem_wbank = !bank_r;
        sw_adv    = 1'b1;
      end
      tgds_pkg::ST_DONE: out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tgds_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r     <= tgds_pkg::DIM_MAX;
      gh_r     <= tgds_pkg::DIM_MAX;
      coeff_r  <= '0;
      init_a_r <= '0;
    end else if (cfg_we) begin
      unique case (tgds_pkg::cfg_idx_t'(cfg_index))
        tgds_pkg::CFG_WIDTH:  gw_r     <= cfg_wdata[tgds_pkg::DIM_W-1:0];
        tgds_pkg::CFG_HEIGHT: gh_r     <= cfg_wdata[tgds_pkg::DIM_W-1:0];
        tgds_pkg::CFG_COEFF:  coeff_r  <= cfg_wdata[tgds_pkg::COEF_W-1:0];
        default:              init_a_r <= cfg_wdata;
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= tgds_pkg::op_t'(in_operation);
      rcol_r  <= in_col;
      rrow_r  <= in_row;
      wcell_r <= {in_conc_c_in, in_conc_b_in, in_conc_a_in};
    end
  end

  // Cell banks with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we && !mem_wbank) begin
      mem0[mem_waddr] <= mem_wdata;
    end
    rd0_r <= mem0[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (mem_we && mem_wbank) begin
      mem1[mem_waddr] <= mem_wdata;
    end
    rd1_r <= mem1[mem_raddr];
  end

  assign rdata = bank_r ? rd1_r : rd0_r;

  // Sweep position, tap counters and bank select.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r   <= 1'b0;
      row_r    <= '0;
      col_r    <= '0;
      kr_r     <= '0;
      kc_r     <= '0;
      ch_r     <= '0;
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= acc_issue;
      if (state_r == tgds_pkg::ST_IDLE) begin
        row_r <= '0;
        col_r <= '0;
      end else if (sw_adv) begin
        {row_r, col_r} <= {row_r, col_r} + 10'd1;
        if (last_cell && state_r != tgds_pkg::ST_CLEAR) begin
          bank_r <= !bank_r;
        end
      end
      if (acc_clr) begin
        kr_r <= '0;
        kc_r <= '0;
        ch_r <= '0;
      end else if (acc_issue) begin
        kc_r <= (kc_r == 2'd2) ? 2'd0 : kc_r + 2'd1;
        if (kc_r == 2'd2) begin
          kr_r <= kr_r + 2'd1;
        end
      end else if (state_r == tgds_pkg::ST_FIN) begin
        ch_r <= ch_r + 2'd1;
      end
    end
  end

  // Stencil accumulation, one tap per cycle.
  always_ff @(posedge clk) begin
    acc_ctr_r <= acc_issue && kr_r == 2'd1 && kc_r == 2'd1;
    for (int i = 0; i < 3; i++) begin
      if (acc_clr) begin
        acc_r[i] <= '0;
      end else if (acc_en_r) begin
        acc_r[i] <= acc_r[i] + {4'd0, rdata[i*CW +: CW]};
      end
      if (acc_en_r && acc_ctr_r) begin
        old_r[i] <= rdata[i*CW +: CW];
      end
    end
    if (state_r == tgds_pkg::ST_FIN) begin
      new_r[ch_r] <= alu_res;
    end
  end

  tgds_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (alu_ctrl),
    .sum9  (acc_r[ch_r]),
    .old   (old_r[ch_r]),
    .coeff (d_eff),
    .res   (alu_res)
  );

  // Pending result.
  always_ff @(posedge clk) begin
    if (state_r == tgds_pkg::ST_EXEC) begin
      res_status_r <= req_oob && (op_r == tgds_pkg::OP_WRITE || op_r == tgds_pkg::OP_READ);
      res_cell_r   <= '0;
    end else if (state_r == tgds_pkg::ST_RDWAIT) begin
      res_cell_r <= rdata;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_cell_r   <= res_cell_r;
    end
  end

  assign in_stall       = (state_r != tgds_pkg::ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_conc_a_out = out_cell_r[0 +: CW];
  assign out_conc_b_out = out_cell_r[CW +: CW];
  assign out_conc_c_out = out_cell_r[2*CW +: CW];

  `TGDS_ASSERT_IMP(a_out_from_done, $rose(out_valid_r), $past(state_r) == tgds_pkg::ST_DONE, "result appeared outside completion")
  `TGDS_ASSERT_IMP(a_reject_zero, out_valid_r && out_status_r, out_cell_r == '0, "rejected access carries data")
  `TGDS_ASSERT_IMP(a_bank_flip, !$stable(bank_r), $past(state_r) == tgds_pkg::ST_SW_WR || $past(state_r) == tgds_pkg::ST_CP_WR, "bank changed outside step end")
  `TGDS_ASSERT_NXT(a_done_idle, state_r == tgds_pkg::ST_DONE && !out_valid_r, state_r == tgds_pkg::ST_IDLE, "completion stuck with free output")

endmodule

// ----- hw/rtl/tgds_alu.sv -----
// Shared update unit: new = old + floor(D * (sum9 - 9*old) / 65536), clamped.
`include "toroidal_grid_diffusion_step_core_defines.svh"

module tgds_alu (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tgds_pkg::alu_ctrl_t           ctrl,
  input  logic [tgds_pkg::SUM_W-1:0]    sum9,
  input  logic [tgds_pkg::CONC_W-1:0]   old,
  input  logic [tgds_pkg::COEF_W-1:0]   coeff,
  output logic [tgds_pkg::CONC_W-1:0]   res
);

  logic [tgds_pkg::SUM_W-1:0] old9;
  logic signed [20:0]         diff;
  logic signed [35:0]         prod_r;
  logic signed [19:0]         q;
  logic signed [20:0]         v;

  // Nine times the center, then the Laplacian term.
  assign old9 = ({4'd0, old} << 3) + {4'd0, old};
  assign diff = $signed({1'b0, sum9}) - $signed({1'b0, old9});

  // One multiply per channel, registered before the final add.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= diff * $signed({1'b0, coeff});
    end
  end

  // Taking the top bits of a two's complement product floors the division.
  assign q = prod_r[35:16];
  assign v = $signed({5'd0, old}) + $signed({q[19], q});

  always_comb begin
    if (v < 0) begin
      res = '0;
    end else if (v > 21'sd65535) begin
      res = '1;
    end else begin
      res = v[tgds_pkg::CONC_W-1:0];
    end
  end

  `TGDS_ASSERT_IMP(a_alu_noclamp, $past(ctrl.mul_en) && coeff <= tgds_pkg::D_CAP, v >= 0 && v <= 21'sd65535, "diffusion update left range under capped coefficient")

endmodule

// ----- tb/sv/toroidal_grid_diffusion_step_core_test.sv -----
module toroidal_grid_diffusion_step_core_test;
  import tgds_pkg::*;

  typedef struct packed {
    op_t         op;
    logic [4:0]  col;
    logic [4:0]  row;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
  } request_t;

  typedef struct packed {
    logic        status;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
  } cell_result_t;

  typedef struct packed {
    request_t     req;
    logic         typed;
    cell_result_t want;
  } directed_row_t;

  localparam cell_result_t ZERO_OK  = '{1'b0, 16'h0, 16'h0, 16'h0};
  localparam cell_result_t OUT_GRID = '{1'b1, 16'h0, 16'h0, 16'h0};
  localparam cell_result_t INIT_RD  = '{1'b0, 16'h1234, 16'h0, 16'h0};
  localparam cell_result_t MAX_RD   = '{1'b0, 16'hffff, 16'hffff, 16'hffff};

  // Directed requests, run on a 5 x 3 grid with the largest coefficient.
  localparam int DIR_N = 20;
  localparam directed_row_t DIR_TAB [DIR_N] = '{
    '{'{OP_CLEAR, 5'd0,  5'd0,  16'h0,    16'h0,    16'h0},    1'b1, ZERO_OK},
    '{'{OP_READ,  5'd0,  5'd0,  16'h0,    16'h0,    16'h0},    1'b1, INIT_RD},
    '{'{OP_READ,  5'd4,  5'd2,  16'hffff, 16'hffff, 16'hffff}, 1'b1, INIT_RD},
    '{'{OP_READ,  5'd5,  5'd0,  16'h0,    16'h0,    16'h0},    1'b1, OUT_GRID},
    '{'{OP_READ,  5'd0,  5'd3,  16'h0,    16'h0,    16'h0},    1'b1, OUT_GRID},
    '{'{OP_WRITE, 5'd31, 5'd31, 16'hffff, 16'hffff, 16'hffff}, 1'b1, OUT_GRID},
    '{'{OP_WRITE, 5'd0,  5'd0,  16'hffff, 16'hffff, 16'hffff}, 1'b1, ZERO_OK},
    '{'{OP_READ,  5'd0,  5'd0,  16'h0,    16'h0,    16'h0},    1'b1, MAX_RD},
    '{'{OP_WRITE, 5'd4,  5'd2,  16'h0,    16'h0,    16'h0},    1'b1, ZERO_OK},
    '{'{OP_WRITE, 5'd1,  5'd1,  16'h8000, 16'h0001, 16'h7fff}, 1'b1, ZERO_OK},
    '{'{OP_STEP,  5'd0,  5'd0,  16'h0,    16'h0,    16'h0},    1'b1, ZERO_OK},
    '{'{OP_READ,  5'd0,  5'd0,  16'h0,    16'h0,    16'h0},    1'b0, ZERO_OK},
    '{'{OP_READ,  5'd1,  5'd0,  16'h0,    16'h0,    16'h0},    1'b0, ZERO_OK},
    '{'{OP_READ,  5'd4,  5'd2,  16'h0,    16'h0,    16'h0},    1'b0, ZERO_OK},
    '{'{OP_READ,  5'd2,  5'd1,  16'h0,    16'h0,    16'h0},    1'b0, ZERO_OK},
    '{'{OP_STEP,  5'd0,  5'd0,  16'h0,    16'h0,    16'h0},    1'b1, ZERO_OK},
    '{'{OP_READ,  5'd1,  5'd1,  16'h0,    16'h0,    16'h0},    1'b0, ZERO_OK},
    '{'{OP_READ,  5'd3,  5'd2,  16'h0,    16'h0,    16'h0},    1'b0, ZERO_OK},
    '{'{OP_CLEAR, 5'd0,  5'd0,  16'h0,    16'h0,    16'h0},    1'b1, ZERO_OK},
    '{'{OP_READ,  5'd2,  5'd2,  16'h0,    16'h0,    16'h0},    1'b1, INIT_RD}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = 2'd0;
  logic [4:0]  in_col = 5'd0;
  logic [4:0]  in_row = 5'd0;
  logic [15:0] in_conc_a_in = 16'h0;
  logic [15:0] in_conc_b_in = 16'h0;
  logic [15:0] in_conc_c_in = 16'h0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_status;
  logic [15:0] out_conc_a_out;
  logic [15:0] out_conc_b_out;
  logic [15:0] out_conc_c_out;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_wdata = 16'h0;

  // Grid model: one current bank is enough since a step copies the whole store.
  logic [15:0] grid_model [1024][3];
  logic [5:0]  width_reg = 6'd32;
  logic [5:0]  height_reg = 6'd32;
  logic [13:0] coeff_reg = 14'd0;
  logic [15:0] init_a_reg = 16'h0;

  cell_result_t pending_results [$];
  int          mismatch_count = 0;
  bit          long_hold_req = 1'b0;
  int          burst_left = 0;

  toroidal_grid_diffusion_step_core u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(12 * 20_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int eff_width();
    if (width_reg == 6'd0) return 1;
    if (width_reg > 6'd32) return 32;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    if (height_reg == 6'd0) return 1;
    if (height_reg > 6'd32) return 32;
    return int'(height_reg);
  endfunction

  // Append one expected result to the scoreboard.
  function automatic void enqueue_result(cell_result_t exp_res);
    pending_results = {pending_results, exp_res};
  endfunction

  // Apply one request to the grid model and return the result it must produce.
  function automatic cell_result_t apply_request(request_t req);
    cell_result_t res;
    logic [15:0]  old_grid [1024][3];
    int           w, h, cell_idx;
    longint       d, sum, old, v;
    res = ZERO_OK;
    w = eff_width();
    h = eff_height();
    d = (coeff_reg > 14'd8192) ? 8192 : longint'(coeff_reg);
    case (req.op)
      OP_WRITE, OP_READ: begin
        if (req.col >= w || req.row >= h) begin
          res.status = 1'b1;
        end else begin
          cell_idx = req.row * 32 + req.col;
          if (req.op == OP_WRITE) begin
            grid_model[cell_idx][0] = req.a;
            grid_model[cell_idx][1] = req.b;
            grid_model[cell_idx][2] = req.c;
          end else begin
            res.a = grid_model[cell_idx][0];
            res.b = grid_model[cell_idx][1];
            res.c = grid_model[cell_idx][2];
          end
        end
      end
      OP_STEP: begin
        old_grid = grid_model;
        for (int r = 0; r < h; r++) begin
          for (int c = 0; c < w; c++) begin
            for (int k = 0; k < 3; k++) begin
              old = old_grid[r * 32 + c][k];
              sum = -old;
              for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                  sum += old_grid[((r + h + dr) % h) * 32 + ((c + w + dc) % w)][k];
                end
              end
              v = old + ((d * (sum - 8 * old)) >>> 16);
              if (v < 0) v = 0;
              if (v > 65535) v = 65535;
              grid_model[r * 32 + c][k] = v[15:0];
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < 1024; i++) begin
          grid_model[i][0] = init_a_reg;
          grid_model[i][1] = 16'h0;
          grid_model[i][2] = 16'h0;
        end
      end
    endcase
    return res;
  endfunction

  task automatic write_register(cfg_idx_t idx, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_WIDTH:  width_reg = value[5:0];
      CFG_HEIGHT: height_reg = value[5:0];
      CFG_COEFF:  coeff_reg = value[13:0];
      default:    init_a_reg = value;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_grid(logic [15:0] w, logic [15:0] h, logic [15:0] d, logic [15:0] ia);
    write_register(CFG_WIDTH, w);
    write_register(CFG_HEIGHT, h);
    write_register(CFG_COEFF, d);
    write_register(CFG_INIT_A, ia);
  endtask

  // Offer one request in bursts with random gaps; record its result once accepted.
  task automatic send_request(request_t req, bit typed, cell_result_t want);
    cell_result_t res;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_operation <= req.op;
    in_col <= req.col;
    in_row <= req.row;
    in_conc_a_in <= req.a;
    in_conc_b_in <= req.b;
    in_conc_c_in <= req.c;
    do @(posedge clk); while (in_stall);
    res = apply_request(req);
    enqueue_result(typed ? want : res);
  endtask

  task automatic drain_results();
    @(posedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic request_t random_request();
    request_t req;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) req.op = OP_WRITE;
    else if (pick < 88) req.op = OP_READ;
    else if (pick < 95) req.op = OP_STEP;
    else req.op = OP_CLEAR;
    if ($urandom_range(0, 4) == 0) begin
      req.col = 5'($urandom_range(0, 31));
      req.row = 5'($urandom_range(0, 31));
    end else begin
      req.col = 5'($urandom_range(0, eff_width() - 1));
      req.row = 5'($urandom_range(0, eff_height() - 1));
    end
    req.a = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom);
    req.b = 16'($urandom);
    req.c = ($urandom_range(0, 7) == 0) ? 16'h0 : 16'($urandom);
    return req;
  endfunction

  // Result checking, then the stall pattern for the next cycle.
  always @(posedge clk) begin
    cell_result_t got, want;
    int hold_cnt, mode;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_status, out_conc_a_out, out_conc_b_out, out_conc_c_out};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Result mismatch: status %b/%b a %h/%h b %h/%h c %h/%h (exp/act)",
                     want.status, got.status, want.a, got.a, want.b, got.b,
                     want.c, got.c);
        end
      end
    end
    if (long_hold_req && hold_cnt == 0) begin
      hold_cnt = 300;
      long_hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin
    logic [15:0] phase_cfg [7][4];
    request_t req;
    phase_cfg = '{
      '{16'd32, 16'd32, 16'($urandom_range(0, 8192)), 16'($urandom)},
      '{16'd1,  16'd1,  16'd8192,  16'hffff},
      '{16'd0,  16'd0,  16'd1000,  16'h0},
      '{16'hffff, 16'hffe8, 16'hffff, 16'h8000},
      '{16'd1,  16'd7,  16'd5000,  16'($urandom)},
      '{16'd7,  16'd1,  16'd8191,  16'($urandom)},
      '{16'd3,  16'd2,  16'($urandom_range(0, 16383)), 16'($urandom)}
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on a small grid.
    set_grid(16'd5, 16'd3, 16'd8192, 16'h1234);
    foreach (DIR_TAB[i]) send_request(DIR_TAB[i].req, DIR_TAB[i].typed, DIR_TAB[i].want);
    drain_results();

    // Random phases; every phase starts from a cleared grid so no read hits an unset cell.
    for (int p = 0; p < 7; p++) begin
      set_grid(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
      req = random_request();
      req.op = OP_CLEAR;
      send_request(req, 1'b0, ZERO_OK);
      for (int n = 0; n < 11; n++) begin
        if (p == 0 && n == 3) long_hold_req = 1'b1;
        send_request(random_request(), 1'b0, ZERO_OK);
      end
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
